// ===== src/assert_macros.svh =====
// assertion macros used by the display scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cdds_pkg.sv =====
// types, constants and helper functions for the charlieplexed display scanner
package cdds_pkg;

    localparam int unsigned NUM_SEGMENTS = 16;
    localparam int unsigned NUM_PINS     = 5;
    localparam int unsigned IDX_W        = 4;
    localparam int unsigned PIN_IDX_W    = 3;
    localparam int unsigned CNT_W        = 16;

    localparam logic [CNT_W-1:0] STEP_INTERVAL_RESET = 16'd300;
    localparam logic [7:0]       VALUE_MAX           = 8'd199;
    localparam logic [7:0]       HUNDRED             = 8'd100;

    // tdata widths of the two stream channels
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_SET_VALUE  = 2'd1,
        ACT_SET_DIGITS = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    typedef logic [PIN_IDX_W-1:0] pin_idx_t;

    // zero-based anode pin of each segment
    function automatic pin_idx_t seg_anode(input logic [IDX_W-1:0] idx);
        pin_idx_t p;
        unique case (idx)
            4'd0:    p = 3'd2;
            4'd1:    p = 3'd1;
            4'd2:    p = 3'd1;
            4'd3:    p = 3'd2;
            4'd4:    p = 3'd3;
            4'd5:    p = 3'd3;
            4'd6:    p = 3'd4;
            4'd7:    p = 3'd4;
            4'd8:    p = 3'd4;
            4'd9:    p = 3'd0;
            4'd10:   p = 3'd1;
            4'd11:   p = 3'd0;
            4'd12:   p = 3'd2;
            4'd13:   p = 3'd0;
            4'd14:   p = 3'd3;
            default: p = 3'd4;
        endcase
        return p;
    endfunction

    // zero-based cathode pin of each segment
    function automatic pin_idx_t seg_cathode(input logic [IDX_W-1:0] idx);
        pin_idx_t p;
        unique case (idx)
            4'd0:    p = 3'd3;
            4'd1:    p = 3'd3;
            4'd2:    p = 3'd2;
            4'd3:    p = 3'd1;
            4'd4:    p = 3'd2;
            4'd5:    p = 3'd1;
            4'd6:    p = 3'd1;
            4'd7:    p = 3'd2;
            4'd8:    p = 3'd3;
            4'd9:    p = 3'd1;
            4'd10:   p = 3'd0;
            4'd11:   p = 3'd2;
            4'd12:   p = 3'd0;
            4'd13:   p = 3'd3;
            4'd14:   p = 3'd0;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

    // seven-segment pattern, bit 0 is segment a, digit taken modulo 10
    function automatic logic [6:0] digit_pattern(input logic [3:0] d);
        logic [3:0] m;
        logic [6:0] p;
        m = (d >= 4'd10) ? d - 4'd10 : d;
        unique case (m)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

    // segment mask: b1/c1, then tens a..g, then units a..g
    function automatic logic [NUM_SEGMENTS-1:0] build_mask(
        input logic       one,
        input logic [3:0] tens,
        input logic [3:0] units
    );
        return {digit_pattern(units), digit_pattern(tens), {2{one}}};
    endfunction

endpackage

// ===== src/charlieplex_digit_display_scanner.sv =====
// charlieplexed 1.88 display scanner with stream input and result channels
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser action, tdata operands
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata pin drive and scan status
//  cfg       in         cfg_valid / cfg_ready          cfg_data step interval
//
// one item is taken per cycle while m_axis is not stalled; each result passes through the
// input register, then the result register, where the display state is updated
// aresetn is synchronous and active low; it clears the mask, counter, scan index and pins
// a stalled m_axis holds the result register and backs up into the input register
// cfg writes are always taken and land in the step interval register at once

`include "assert_macros.svh"

module charlieplex_digit_display_scanner (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] value, [16] show_one, [20:17] tens_digit, [24:21] units_digit, rest zero
    input  logic [cdds_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                      s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [4:0] pin_drive, [9:5] pin_high, [10] stepped, [14:11] scan_position, [15] zero
    output logic [cdds_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cdds_pkg::CNT_W-1:0]      cfg_data
);

    import cdds_pkg::*;

    // input register
    logic                   in_valid_reg;
    action_t                in_action_reg;
    logic [15:0]            in_value_reg;
    logic                   in_one_reg;
    logic [3:0]             in_tens_reg;
    logic [3:0]             in_units_reg;

    // display state
    logic [CNT_W-1:0]        step_interval_reg;
    logic [NUM_SEGMENTS-1:0] seg_mask_reg;
    logic [NUM_SEGMENTS-1:0] seg_mask_next;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic [IDX_W-1:0]        scan_idx_next;
    logic [CNT_W-1:0]        elapsed_reg;
    logic [CNT_W-1:0]        elapsed_next;
    logic [NUM_PINS-1:0]     drive_en_reg;
    logic [NUM_PINS-1:0]     drive_en_next;
    logic [NUM_PINS-1:0]     drive_lvl_reg;
    logic [NUM_PINS-1:0]     drive_lvl_next;
    logic                    stepped_next;

    // result register
    logic                    out_valid_reg;
    logic [M_TDATA_W-1:0]    out_data_reg;

    logic                    out_free;
    logic                    advance;

    // value path
    logic [7:0]              val_sat;
    logic                    val_one;
    logic [6:0]              val_rem;
    logic [14:0]             val_prod;
    logic [3:0]              val_tens;
    logic [6:0]              val_tens_x10;
    logic [3:0]              val_units;

    // tick path
    logic [CNT_W-1:0]        elapsed_inc;
    logic                    step_due;
    pin_idx_t                anode;
    pin_idx_t                cathode;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_action_reg <= action_t'(s_axis_tuser);
            in_value_reg  <= s_axis_tdata[15:0];
            in_one_reg    <= s_axis_tdata[16];
            in_tens_reg   <= s_axis_tdata[20:17];
            in_units_reg  <= s_axis_tdata[24:21];
        end
    end

    // saturate to 199, strip the hundred, split tens and units (r * 205 >> 11 is r / 10)
    always_comb begin
        val_sat      = (in_value_reg > {8'd0, VALUE_MAX}) ? VALUE_MAX : in_value_reg[7:0];
        val_one      = (val_sat >= HUNDRED);
        val_rem      = val_one ? 7'(val_sat - HUNDRED) : val_sat[6:0];
        val_prod     = 15'(val_rem) * 15'd205;
        val_tens     = val_prod[14:11];
        val_tens_x10 = 7'(val_tens) * 7'd10;
        val_units    = 4'(val_rem - val_tens_x10);
    end

    // saturating tick counter and scanned segment pins
    always_comb begin
        elapsed_inc = (elapsed_reg == {CNT_W{1'b1}}) ? elapsed_reg : elapsed_reg + 1'b1;
        step_due    = (elapsed_inc >= step_interval_reg);
        anode       = seg_anode(scan_idx_reg);
        cathode     = seg_cathode(scan_idx_reg);
    end

    // next display state per action
    always_comb begin
        seg_mask_next  = seg_mask_reg;
        scan_idx_next  = scan_idx_reg;
        elapsed_next   = elapsed_reg;
        drive_en_next  = drive_en_reg;
        drive_lvl_next = drive_lvl_reg;
        stepped_next   = 1'b0;
        unique case (in_action_reg)
            ACT_TICK: begin
                elapsed_next = elapsed_inc;
                if (step_due) begin
                    elapsed_next  = '0;
                    stepped_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                    if (seg_mask_reg[scan_idx_reg]) begin
                        drive_en_next  = (NUM_PINS'(1) << anode) | (NUM_PINS'(1) << cathode);
                        drive_lvl_next = NUM_PINS'(1) << anode;
                    end else begin
                        drive_en_next  = '0;
                        drive_lvl_next = '0;
                    end
                end
            end
            ACT_SET_VALUE: begin
                seg_mask_next = build_mask(val_one, val_tens, val_units);
            end
            ACT_SET_DIGITS: begin
                seg_mask_next = build_mask(in_one_reg, in_tens_reg, in_units_reg);
            end
            ACT_CLEAR: begin
                seg_mask_next = '0;
            end
            default: begin
                seg_mask_next = seg_mask_reg;
            end
        endcase
    end

    // step interval register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_interval_reg <= STEP_INTERVAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            step_interval_reg <= cfg_data;
        end
    end

    // display state, updated as an item moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_mask_reg  <= '0;
            scan_idx_reg  <= '0;
            elapsed_reg   <= '0;
            drive_en_reg  <= '0;
            drive_lvl_reg <= '0;
        end else if (advance) begin
            seg_mask_reg  <= seg_mask_next;
            scan_idx_reg  <= scan_idx_next;
            elapsed_reg   <= elapsed_next;
            drive_en_reg  <= drive_en_next;
            drive_lvl_reg <= drive_lvl_next;
        end
    end

    // result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {1'b0, scan_idx_next, stepped_next, drive_lvl_next, drive_en_next};
        end
    end

    // driven-high pins are always among the driven pins
    `ASSERT_CLK(a_high_within_drive, (drive_lvl_reg & ~drive_en_reg) == '0,
        "pin driven high without its enable")

    // either all pins float or exactly one anode and one cathode are driven
    `ASSERT_CLK(a_two_pins_or_none,
        ($countones(drive_en_reg) == 0) || ($countones(drive_en_reg) == 2),
        "wrong number of driven pins")

    // a scan step moves the index on by one
    `ASSERT_IMPL(a_scan_advances, advance && stepped_next,
        scan_idx_reg == IDX_W'($past(scan_idx_reg) + 1'b1), "scan index did not advance")

endmodule

// ===== dv/charlieplex_digit_display_scanner_tb.sv =====
// self-checking testbench for the charlieplexed display scanner
`timescale 1ns / 1ps

module charlieplex_digit_display_scanner_tb;
    import cdds_pkg::*;

    // one command on the input stream
    typedef struct {
        action_t     act;
        logic [15:0] value;
        logic        show_one;
        logic [3:0]  tens;
        logic [3:0]  units;
    } disp_cmd_t;

    // one result: pin drive and scan status
    typedef struct {
        logic [4:0] drive;
        logic [4:0] high;
        logic       stepped;
        logic [3:0] pos;
    } pin_state_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_KNOWN,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        disp_cmd_t  cmd;
        pin_state_t want;
    } stim_row_t;

    // one-based anode and cathode pin of each segment
    localparam logic [2:0] ANODE_PIN [16] = '{
        3'd3, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
        3'd5, 3'd1, 3'd2, 3'd1, 3'd3, 3'd1, 3'd4, 3'd5
    };
    localparam logic [2:0] CATHODE_PIN [16] = '{
        3'd4, 3'd4, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd3,
        3'd4, 3'd2, 3'd1, 3'd3, 3'd1, 3'd4, 3'd1, 3'd1
    };
    // seven-segment glyphs, bit 0 is segment a
    localparam logic [6:0] GLYPH [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data      = '0;

    // predicted display state
    logic [15:0] pm_interval;
    logic [15:0] pm_mask;
    logic [3:0]  pm_index;
    logic [15:0] pm_ticks;
    logic [4:0]  pm_drive;
    logic [4:0]  pm_high;

    pin_state_t  pending_pins [$];
    stim_row_t   directed_rows [$];
    int          mismatches = 0;
    int          idle_after = 0;
    bit          no_gaps    = 1'b0;

    charlieplex_digit_display_scanner uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    // run limit well above the slowest correct run
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // segment mask from leading one, tens and units digits (already below ten)
    function automatic logic [15:0] glyph_mask(input logic one, input logic [3:0] tens,
                                               input logic [3:0] units);
        return {GLYPH[units], GLYPH[tens], one, one};
    endfunction

    // advance the predicted display by one command and return the pin state
    function automatic pin_state_t predict_pins(input disp_cmd_t cmd);
        pin_state_t  r;
        logic [15:0] v;
        logic        one;
        logic [2:0]  a;
        logic [2:0]  c;
        r.stepped = 1'b0;
        case (cmd.act)
            ACT_TICK: begin
                if (pm_ticks != 16'hFFFF) pm_ticks = pm_ticks + 16'd1;
                if (pm_ticks >= pm_interval) begin
                    pm_ticks  = '0;
                    r.stepped = 1'b1;
                    if (pm_mask[pm_index]) begin
                        a        = ANODE_PIN[pm_index] - 3'd1;
                        c        = CATHODE_PIN[pm_index] - 3'd1;
                        pm_drive = (5'd1 << a) | (5'd1 << c);
                        pm_high  = 5'd1 << a;
                    end else begin
                        pm_drive = '0;
                        pm_high  = '0;
                    end
                    pm_index = pm_index + 4'd1;
                end
            end
            ACT_SET_VALUE: begin
                v   = (cmd.value > 16'd199) ? 16'd199 : cmd.value;
                one = (v >= 16'd100);
                if (one) v = v - 16'd100;
                pm_mask = glyph_mask(one, 4'(v / 10), 4'(v % 10));
            end
            ACT_SET_DIGITS: begin
                pm_mask = glyph_mask(cmd.show_one, 4'(cmd.tens % 10), 4'(cmd.units % 10));
            end
            default: begin
                pm_mask = '0;
            end
        endcase
        r.drive = pm_drive;
        r.high  = pm_high;
        r.pos   = pm_index;
        return r;
    endfunction

    // random command, values clustered around the saturation and hundreds edges
    function automatic disp_cmd_t random_cmd();
        disp_cmd_t cmd;
        int        r;
        r = $urandom_range(0, 99);
        if (r < 65)      cmd.act = ACT_TICK;
        else if (r < 78) cmd.act = ACT_SET_VALUE;
        else if (r < 92) cmd.act = ACT_SET_DIGITS;
        else             cmd.act = ACT_CLEAR;
        case ($urandom_range(0, 3))
            0:       cmd.value = 16'($urandom);
            1:       cmd.value = 16'($urandom_range(0, 255));
            2:       cmd.value = 16'($urandom_range(90, 210));
            default: cmd.value = 16'($urandom_range(0, 199));
        endcase
        cmd.show_one = 1'($urandom);
        cmd.tens     = 4'($urandom);
        cmd.units    = 4'($urandom);
        return cmd;
    endfunction

    // directed table row
    task automatic add_row(input row_kind_t kind, input action_t act, input logic [15:0] value,
                           input logic one, input logic [3:0] tens, input logic [3:0] units,
                           input logic [4:0] drv, input logic [4:0] hi, input logic stp,
                           input logic [3:0] pos);
        stim_row_t row;
        row.kind          = kind;
        row.cmd.act       = act;
        row.cmd.value     = value;
        row.cmd.show_one  = one;
        row.cmd.tens      = tens;
        row.cmd.units     = units;
        row.want.drive    = drv;
        row.want.high     = hi;
        row.want.stepped  = stp;
        row.want.pos      = pos;
        directed_rows.push_back(row);
    endtask

    // send one command and queue its expected pins once the transfer happens
    task automatic send_cmd(input disp_cmd_t cmd, input bit known, input pin_state_t want);
        pin_state_t pred;
        if (idle_after != 0) repeat (idle_after) @(posedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd.act;
        s_axis_tdata  <= {7'd0, cmd.units, cmd.tens, cmd.show_one, cmd.value};
        do @(posedge aclk); while (!s_axis_tready);
        pred = predict_pins(cmd);
        pending_pins.push_back(known ? want : pred);
        idle_after = no_gaps ? 0 : pick_gap();
        if (idle_after != 0) s_axis_tvalid <= 1'b0;
    endtask

    // stop sending and wait for every expected result
    task automatic settle();
        if (idle_after == 0) s_axis_tvalid <= 1'b0;
        idle_after = 0;
        @(posedge aclk);
        while (pending_pins.size() != 0) @(posedge aclk);
    endtask

    // write the step interval with the block idle
    task automatic write_interval(input logic [15:0] iv);
        settle();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= iv;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        pm_interval = iv;
    endtask

    // result side: random stalls, compare each transfer with the oldest expectation
    initial begin
        int         stall_left;
        pin_state_t want;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                if (pending_pins.size() == 0) begin
                    $error("result transfer with nothing expected: %0h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pending_pins.pop_front();
                    if (m_axis_tdata[4:0] !== want.drive) begin
                        $error("pin_drive: expected %0h, got %0h", want.drive, m_axis_tdata[4:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[9:5] !== want.high) begin
                        $error("pin_high: expected %0h, got %0h", want.high, m_axis_tdata[9:5]);
                        mismatches++;
                    end
                    if (m_axis_tdata[10] !== want.stepped) begin
                        $error("stepped: expected %0d, got %0d", want.stepped, m_axis_tdata[10]);
                        mismatches++;
                    end
                    if (m_axis_tdata[14:11] !== want.pos) begin
                        $error("scan_position: expected %0d, got %0d", want.pos,
                               m_axis_tdata[14:11]);
                        mismatches++;
                    end
                end
            end
            if (aresetn) begin
                if (stall_left != 0 && !no_gaps) begin
                    m_axis_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_axis_tready <= 1'b1;
                    stall_left = 0;
                    if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
                end
            end
        end
    end

    // stimulus
    initial begin
        pin_state_t  none;
        disp_cmd_t   cmd;
        logic [15:0] phase_iv [8];
        none = '{default: '0};

        pm_interval = STEP_INTERVAL_RESET;
        pm_mask     = '0;
        pm_index    = '0;
        pm_ticks    = '0;
        pm_drive    = '0;
        pm_high     = '0;

        // reset
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset interval, no step, pins stay floating
        add_row(ROW_KNOWN, ACT_TICK,       16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_SET_VALUE,  16'hFFFF,  1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_SET_VALUE,  16'd200,   1'b1, 4'd15, 4'd15, 5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_SET_VALUE,  16'd199,   1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_SET_VALUE,  16'd100,   1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_SET_VALUE,  16'd99,    1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_SET_VALUE,  16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_SET_DIGITS, 16'd0,     1'b1, 4'd15, 4'd15, 5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_SET_DIGITS, 16'hFFFF,  1'b0, 4'd10, 4'd9,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_CLEAR,      16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        // interval zero: every tick steps; blank mask floats all pins
        add_row(ROW_CFG,   ACT_TICK,       16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_KNOWN, ACT_TICK,       16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b1, 4'd1);
        // all segments lit, walk part of the scan
        add_row(ROW_ITEM,  ACT_SET_DIGITS, 16'd0,     1'b1, 4'd8,  4'd8,  5'd0, 5'd0, 1'b0, 4'd0);
        repeat (8)
            add_row(ROW_ITEM, ACT_TICK,    16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_ITEM,  ACT_SET_VALUE,  16'hFFFF,  1'b1, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_ITEM,  ACT_TICK,       16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_ITEM,  ACT_CLEAR,      16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);
        add_row(ROW_ITEM,  ACT_TICK,       16'd0,     1'b0, 4'd0,  4'd0,  5'd0, 5'd0, 1'b0, 4'd0);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_CFG:   write_interval(directed_rows[i].cmd.value);
                ROW_KNOWN: send_cmd(directed_rows[i].cmd, 1'b1, directed_rows[i].want);
                default:   send_cmd(directed_rows[i].cmd, 1'b0, none);
            endcase
        end

        // largest interval: a short run of back-to-back ticks, none of them steps
        write_interval(16'hFFFF);
        no_gaps = 1'b1;
        cmd = '{act: ACT_SET_DIGITS, value: 16'd0, show_one: 1'b1, tens: 4'd8, units: 4'd8};
        send_cmd(cmd, 1'b0, none);
        repeat (24) begin
            cmd     = random_cmd();
            cmd.act = ACT_TICK;
            send_cmd(cmd, 1'b0, none);
        end
        no_gaps = 1'b0;

        // random phases over a range of intervals
        phase_iv[0] = 16'd1;
        phase_iv[1] = 16'd2;
        phase_iv[2] = 16'd0;
        phase_iv[3] = 16'($urandom_range(3, 12));
        phase_iv[4] = STEP_INTERVAL_RESET;
        phase_iv[5] = 16'($urandom_range(13, 60));
        phase_iv[6] = 16'($urandom);
        phase_iv[7] = 16'd1;
        foreach (phase_iv[p]) begin
            write_interval(phase_iv[p]);
            no_gaps = (p == 3);
            repeat (70) begin
                if ($urandom_range(0, 39) == 0) settle();
                send_cmd(random_cmd(), 1'b0, none);
            end
        end
        no_gaps = 1'b0;

        // drain and let the pipeline run dry
        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/cdds_pkg.sv
src/charlieplex_digit_display_scanner.sv
dv/charlieplex_digit_display_scanner_tb.sv
